/* rtl/dpfsm_pkg.sv */
`timescale 1ns / 1ps
package dpfsm_pkg;

  // Event kinds
  localparam logic [3:0] KIND_TICK        = 4'd0;
  localparam logic [3:0] KIND_ACCEPT      = 4'd1;
  localparam logic [3:0] KIND_CONNECTED   = 4'd2;
  localparam logic [3:0] KIND_CONN_PEND   = 4'd3;
  localparam logic [3:0] KIND_CONN_FAIL   = 4'd4;
  localparam logic [3:0] KIND_CLOSE       = 4'd5;
  localparam logic [3:0] KIND_TXN_TIMEOUT = 4'd6;
  localparam logic [3:0] KIND_CEA         = 4'd7;
  localparam logic [3:0] KIND_CER         = 4'd8;
  localparam logic [3:0] KIND_DWR         = 4'd9;
  localparam logic [3:0] KIND_DWA         = 4'd10;
  localparam logic [3:0] KIND_DPR         = 4'd11;
  localparam logic [3:0] KIND_DPA         = 4'd12;
  localparam logic [3:0] KIND_HANGUP      = 4'd13;

  // Peer states
  localparam logic [2:0] ST_UNCONN   = 3'd0;
  localparam logic [2:0] ST_WAIT_CER = 3'd1;
  localparam logic [2:0] ST_WAIT_CEA = 3'd2;
  localparam logic [2:0] ST_CONN     = 3'd3;
  localparam logic [2:0] ST_WAIT_DWA = 3'd4;
  localparam logic [2:0] ST_WAIT_DPA = 3'd5;

  // Timer kinds
  localparam logic [1:0] TK_NONE    = 2'd0;
  localparam logic [1:0] TK_RECONN  = 2'd1;
  localparam logic [1:0] TK_WAITCER = 2'd2;

  // Messages and commands to send
  localparam logic [2:0] MSG_NONE    = 3'd0;
  localparam logic [2:0] MSG_CER     = 3'd1;
  localparam logic [2:0] MSG_CEA     = 3'd2;
  localparam logic [2:0] MSG_DWA     = 3'd3;
  localparam logic [2:0] MSG_CONNECT = 3'd4;

  // Answer codes
  localparam logic [1:0] ANS_SUCCESS   = 2'd0;
  localparam logic [1:0] ANS_MISSING   = 2'd1;
  localparam logic [1:0] ANS_NO_COMMON = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MISMATCH = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOCAL_ACC  = 2'd0;
  localparam logic [1:0] CFG_LOCAL_AUTH = 2'd1;
  localparam logic [1:0] CFG_WAIT_CER   = 2'd2;
  localparam logic [1:0] CFG_RECONNECT  = 2'd3;

  // AVP presence checks
  localparam logic [5:0] CEA_NEED = 6'h3f;
  localparam logic [5:0] CER_NEED = 6'h3e;
  localparam logic [5:0] DW_BITS  = 6'h07;
  localparam logic [5:0] DWR_NEED = 6'h06;

  // Reset values of the tick registers
  localparam int unsigned WAIT_CER_RESET  = 5;
  localparam int unsigned RECONNECT_RESET = 30;

  typedef struct packed {
    logic [2:0] peer_state;
    logic       conn_in_progress;
    logic [1:0] timer_kind;
  } ctl_t;

  typedef struct packed {
    logic [2:0] send_msg;
    logic [1:0] answer_code;
    logic       close_conn;
    logic [2:0] new_state;
    logic [1:0] err_code;
  } result_t;

endpackage

/* rtl/diameter_peer_fsm_core.sv */
`timescale 1ns / 1ps
// Diameter peer state machine. Each request is one event (tick, TCP event,
// timeout, received CE/DW/DP message or hangup) and yields exactly one result:
// what to send, the answer code, a close flag, the new peer state and an error
// code. One request is taken every cycle while in_stall_o is low. A request
// is held in the input register, and the single pass of logic behind it
// loads the result register and updates the peer state at the same edge,
// once the result register is free, so the result is presented from the
// result register. A stalled result holds the input register; a new
// request is still taken whenever the input register empties in the same
// cycle. Configuration writes take effect on the next request and should be
// made while idle.
module diameter_peer_fsm_core #(
  parameter int unsigned APP_COUNT  = 5,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [3:0]            kind_i,
  input  logic [5:0]            avp_present_i,
  input  logic                  result_success_i,
  input  logic [APP_COUNT-1:0]  msg_acc_apps_i,
  input  logic [APP_COUNT-1:0]  msg_auth_apps_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            send_msg_o,
  output logic [1:0]            answer_code_o,
  output logic                  close_conn_o,
  output logic [2:0]            new_state_o,
  output logic [1:0]            error_code_o,

  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [((TIMER_BITS > APP_COUNT) ? TIMER_BITS : APP_COUNT)-1:0] cfg_wdata_i
);
  import dpfsm_pkg::*;

  // Configuration registers
  logic [APP_COUNT-1:0]  local_acc_q;
  logic [APP_COUNT-1:0]  local_auth_q;
  logic [TIMER_BITS-1:0] wait_cer_q;
  logic [TIMER_BITS-1:0] reconnect_q;

  // Peer state
  ctl_t                  ctl_q, ctl_d;
  logic [TIMER_BITS-1:0] timer_left_q, timer_left_d;
  logic [APP_COUNT-1:0]  peer_acc_q, peer_acc_d;
  logic [APP_COUNT-1:0]  peer_auth_q, peer_auth_d;

  // Input register
  logic                  in_valid_q;
  logic [3:0]            kind_q;
  logic [5:0]            avp_q;
  logic                  ok_q;
  logic [APP_COUNT-1:0]  macc_q;
  logic [APP_COUNT-1:0]  mauth_q;

  // Result register
  logic                  out_valid_q;
  result_t               res_q, res_d;

  logic out_free;
  logic advance;
  logic in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_acc_q  <= '0;
      local_auth_q <= '0;
      wait_cer_q   <= TIMER_BITS'(WAIT_CER_RESET);
      reconnect_q  <= TIMER_BITS'(RECONNECT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOCAL_ACC:  local_acc_q  <= cfg_wdata_i[APP_COUNT-1:0];
        CFG_LOCAL_AUTH: local_auth_q <= cfg_wdata_i[APP_COUNT-1:0];
        CFG_WAIT_CER:   wait_cer_q   <= cfg_wdata_i[TIMER_BITS-1:0];
        CFG_RECONNECT:  reconnect_q  <= cfg_wdata_i[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= kind_i;
      avp_q   <= avp_present_i;
      ok_q    <= result_success_i;
      macc_q  <= msg_acc_apps_i;
      mauth_q <= msg_auth_apps_i;
    end
  end

  dpfsm_step #(
    .APP_COUNT  (APP_COUNT),
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .ctl_i             (ctl_q),
    .timer_left_i      (timer_left_q),
    .peer_acc_i        (peer_acc_q),
    .peer_auth_i       (peer_auth_q),
    .local_acc_i       (local_acc_q),
    .local_auth_i      (local_auth_q),
    .wait_cer_ticks_i  (wait_cer_q),
    .reconnect_ticks_i (reconnect_q),
    .kind_i            (kind_q),
    .avp_present_i     (avp_q),
    .result_success_i  (ok_q),
    .msg_acc_apps_i    (macc_q),
    .msg_auth_apps_i   (mauth_q),
    .ctl_o             (ctl_d),
    .timer_left_o      (timer_left_d),
    .peer_acc_o        (peer_acc_d),
    .peer_auth_o       (peer_auth_d),
    .res_o             (res_d)
  );

  // Commit the state update when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q        <= '{peer_state: ST_UNCONN, conn_in_progress: 1'b0, timer_kind: TK_NONE};
      timer_left_q <= '0;
      peer_acc_q   <= '0;
      peer_auth_q  <= '0;
    end else if (advance) begin
      ctl_q        <= ctl_d;
      timer_left_q <= timer_left_d;
      peer_acc_q   <= peer_acc_d;
      peer_auth_q  <= peer_auth_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign send_msg_o    = res_q.send_msg;
  assign answer_code_o = res_q.answer_code;
  assign close_conn_o  = res_q.close_conn;
  assign new_state_o   = res_q.new_state;
  assign error_code_o  = res_q.err_code;

  // A rejected event leaves the peer state and the connect flag untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.err_code != ERR_NONE) |=>
      (ctl_q.peer_state == $past(ctl_q.peer_state) &&
       ctl_q.conn_in_progress == $past(ctl_q.conn_in_progress)))
    else $error("rejected event changed peer state");

  // Only the six defined states are ever reached
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.peer_state <= ST_WAIT_DPA)
    else $error("peer state out of range");

  // No timer kind beyond reconnect and wait-for-CER
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q.timer_kind <= TK_WAITCER)
    else $error("invalid timer kind");

  // A nonzero answer code only comes with a CEA or DWA
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.answer_code != ANS_SUCCESS) |->
      (res_q.send_msg == MSG_CEA || res_q.send_msg == MSG_DWA))
    else $error("answer code without an answer message");

  // Result state always matches the committed peer state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (res_q.new_state == ctl_q.peer_state))
    else $error("reported state differs from committed state");

endmodule

/* rtl/dpfsm_step.sv */
`timescale 1ns / 1ps
module dpfsm_step #(
  parameter int unsigned APP_COUNT  = 5,
  parameter int unsigned TIMER_BITS = 16
) (
  input  dpfsm_pkg::ctl_t        ctl_i,
  input  logic [TIMER_BITS-1:0]  timer_left_i,
  input  logic [APP_COUNT-1:0]   peer_acc_i,
  input  logic [APP_COUNT-1:0]   peer_auth_i,
  input  logic [APP_COUNT-1:0]   local_acc_i,
  input  logic [APP_COUNT-1:0]   local_auth_i,
  input  logic [TIMER_BITS-1:0]  wait_cer_ticks_i,
  input  logic [TIMER_BITS-1:0]  reconnect_ticks_i,
  input  logic [3:0]             kind_i,
  input  logic [5:0]             avp_present_i,
  input  logic                   result_success_i,
  input  logic [APP_COUNT-1:0]   msg_acc_apps_i,
  input  logic [APP_COUNT-1:0]   msg_auth_apps_i,
  output dpfsm_pkg::ctl_t        ctl_o,
  output logic [TIMER_BITS-1:0]  timer_left_o,
  output logic [APP_COUNT-1:0]   peer_acc_o,
  output logic [APP_COUNT-1:0]   peer_auth_o,
  output dpfsm_pkg::result_t     res_o
);
  import dpfsm_pkg::*;

  logic                  fail_reset;
  logic [APP_COUNT-1:0]  acc_merged;
  logic [APP_COUNT-1:0]  auth_merged;
  logic                  common_app;
  logic                  in_unconn;
  ctl_t                  ctl;
  logic [TIMER_BITS-1:0] tmr;
  logic [APP_COUNT-1:0]  acc;
  logic [APP_COUNT-1:0]  auth;
  result_t               res;

  assign acc_merged  = peer_acc_i | msg_acc_apps_i;
  assign auth_merged = peer_auth_i | msg_auth_apps_i;
  assign common_app  = |((acc_merged & local_acc_i) | (auth_merged & local_auth_i));
  assign in_unconn   = (ctl_i.peer_state == ST_UNCONN);

  always_comb begin
    ctl        = ctl_i;
    tmr        = timer_left_i;
    acc        = peer_acc_i;
    auth       = peer_auth_i;
    res        = '0;
    fail_reset = 1'b0;

    case (kind_i)
      KIND_TICK: begin
        if (ctl_i.timer_kind != TK_NONE) begin
          if (timer_left_i > TIMER_BITS'(1)) begin
            tmr = timer_left_i - TIMER_BITS'(1);
          end else begin
            ctl.timer_kind = TK_NONE;
            tmr            = '0;
            if (ctl_i.timer_kind == TK_RECONN) begin
              if (in_unconn) begin
                res.close_conn = ctl_i.conn_in_progress;
                res.send_msg   = MSG_CONNECT;
              end
            end else if (ctl_i.peer_state == ST_WAIT_CER) begin
              res.close_conn = 1'b1;
              fail_reset     = 1'b1;
            end else begin
              res.err_code = ERR_MISMATCH;
            end
          end
        end
      end
      KIND_ACCEPT: begin
        if (in_unconn) begin
          // Drop a stale outbound attempt unless a reconnect is still pending
          if (ctl_i.timer_kind != TK_RECONN && ctl_i.conn_in_progress) begin
            res.close_conn = 1'b1;
          end
          ctl.timer_kind = TK_WAITCER;
          tmr            = wait_cer_ticks_i;
          ctl.peer_state = ST_WAIT_CER;
        end else begin
          res.err_code = ERR_MISMATCH;
        end
      end
      KIND_CONNECTED: begin
        if (in_unconn) begin
          ctl.conn_in_progress = 1'b0;
          res.send_msg         = MSG_CER;
          ctl.peer_state       = ST_WAIT_CEA;
        end else begin
          res.err_code = ERR_MISMATCH;
        end
      end
      KIND_CONN_PEND: begin
        if (in_unconn) ctl.conn_in_progress = 1'b1;
        else res.err_code = ERR_MISMATCH;
      end
      KIND_CONN_FAIL: begin
        if (in_unconn) fail_reset = 1'b1;
        else res.err_code = ERR_MISMATCH;
      end
      KIND_CLOSE: begin
        res.close_conn = 1'b1;
        fail_reset     = 1'b1;
      end
      KIND_TXN_TIMEOUT: begin
        if (ctl_i.peer_state == ST_WAIT_CEA || ctl_i.peer_state == ST_WAIT_DPA) begin
          res.close_conn = 1'b1;
          fail_reset     = 1'b1;
        end else begin
          res.err_code = ERR_MISMATCH;
        end
      end
      KIND_CEA: begin
        if (ctl_i.peer_state == ST_WAIT_CEA) begin
          acc  = acc_merged;
          auth = auth_merged;
          if (avp_present_i != CEA_NEED || !result_success_i) begin
            res.close_conn = 1'b1;
            fail_reset     = 1'b1;
          end else begin
            ctl.peer_state = ST_CONN;
          end
        end else begin
          res.err_code = ERR_MISMATCH;
        end
      end
      KIND_CER: begin
        if (ctl_i.peer_state == ST_WAIT_CER || ctl_i.peer_state == ST_WAIT_CEA) begin
          // Stop the wait-for-CER timer once the CER shows up
          if (ctl_i.peer_state == ST_WAIT_CER && ctl_i.timer_kind == TK_WAITCER) begin
            ctl.timer_kind = TK_NONE;
            tmr            = '0;
          end
          acc          = acc_merged;
          auth         = auth_merged;
          res.send_msg = MSG_CEA;
          if (avp_present_i != CER_NEED) begin
            res.answer_code = ANS_MISSING;
            res.close_conn  = 1'b1;
            fail_reset      = 1'b1;
          end else if (common_app) begin
            res.answer_code = ANS_SUCCESS;
            ctl.peer_state  = ST_CONN;
          end else begin
            res.answer_code = ANS_NO_COMMON;
            res.close_conn  = 1'b1;
            fail_reset      = 1'b1;
          end
        end else begin
          res.err_code = ERR_MISMATCH;
        end
      end
      KIND_DWR: begin
        if (ctl_i.peer_state == ST_CONN || ctl_i.peer_state == ST_WAIT_DWA ||
            ctl_i.peer_state == ST_WAIT_DPA) begin
          res.send_msg    = MSG_DWA;
          res.answer_code = ((avp_present_i & DW_BITS) != DWR_NEED) ? ANS_MISSING
                                                                    : ANS_SUCCESS;
        end else begin
          res.err_code = ERR_MISMATCH;
        end
      end
      KIND_DWA: begin
        if (ctl_i.peer_state == ST_WAIT_DWA) ctl.peer_state = ST_CONN;
        else res.err_code = ERR_MISMATCH;
      end
      KIND_DPR: begin
        if (ctl_i.peer_state == ST_CONN) fail_reset = 1'b1;
        else res.err_code = ERR_MISMATCH;
      end
      KIND_DPA: begin
        if (ctl_i.peer_state == ST_WAIT_DPA) fail_reset = 1'b1;
        else res.err_code = ERR_MISMATCH;
      end
      KIND_HANGUP: begin
        if (ctl_i.peer_state == ST_CONN) ctl.peer_state = ST_WAIT_DPA;
        else res.err_code = ERR_MISMATCH;
      end
      default: begin
        res.err_code = ERR_UNKNOWN;
      end
    endcase

    // Peer reset: forget the peer and arm the reconnect timer
    if (fail_reset) begin
      ctl.conn_in_progress = 1'b0;
      ctl.timer_kind       = TK_RECONN;
      ctl.peer_state       = ST_UNCONN;
      tmr                  = reconnect_ticks_i;
      acc                  = '0;
      auth                 = '0;
    end

    res.new_state = ctl.peer_state;
  end

  assign ctl_o        = ctl;
  assign timer_left_o = tmr;
  assign peer_acc_o   = acc;
  assign peer_auth_o  = auth;
  assign res_o        = res;

endmodule
